// ===== src/rhmw_pkg.sv =====
// ----------------------------------------------------------------------------
// rhmw_pkg: shared definitions for the right-hand maze walker
// Command, status, heading and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package rhmw_pkg;

  // Commands carried by an input beat
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_STEP    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_IDLE       = 3'd0;
  localparam logic [2:0] STAT_MOVED      = 3'd1;
  localparam logic [2:0] STAT_SOLVED     = 3'd2;
  localparam logic [2:0] STAT_UNSOLVABLE = 3'd3;
  localparam logic [2:0] STAT_NO_MOVE    = 3'd4;

  // Headings
  localparam logic [1:0] HEAD_S = 2'd0;
  localparam logic [1:0] HEAD_E = 2'd1;
  localparam logic [1:0] HEAD_N = 2'd2;
  localparam logic [1:0] HEAD_W = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_SROW  = 3'd2;
  localparam logic [2:0] REG_SCOL  = 3'd3;
  localparam logic [2:0] REG_SHEAD = 3'd4;
  localparam logic [2:0] REG_GROW  = 3'd5;
  localparam logic [2:0] REG_GCOL  = 3'd6;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_PROBE = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

endpackage

// ===== src/right_hand_maze_walker.sv =====
// ----------------------------------------------------------------------------
// right_hand_maze_walker: wall-following maze walker
// One-bit-per-cell maze memory and a small sequencer that probes the
// neighbours right, forward, left and back through one address/bounds unit.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | command, cell_row, cell_col,
//           |           |                        | cell_open
//   out_    | output    | out_valid / out_ready  | pos_row, pos_col, heading,
//           |           |                        | status
//   APB     | input     | psel, penable, pready  | paddr, pwdata, prdata
//
// Write, restart, unknown command: accept, then result load.
// Step: accept, the check state, then for each probed neighbour (up to four)
// an address state and a registered read on the single memory read port,
// then the result load.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register while the next beat is accepted, and the next result
// load stalls while that register is still full.
// Reset (synchronous) loads register defaults and the start walker; the maze
// memory is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module right_hand_maze_walker #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_cell_row,
  input  logic [4:0]  in_cell_col,
  input  logic        in_cell_open,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_pos_row,
  output logic [4:0]  out_pos_col,
  output logic [1:0]  out_heading,
  output logic [2:0]  out_status,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rhmw_pkg::*;

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int WR_W   = (ROW_AW > 4) ? ROW_AW : 4;
  localparam int WC_W   = (COL_AW > 5) ? COL_AW : 5;
  localparam int NR_W   = WR_W + 1;
  localparam int NC_W   = WC_W + 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Configuration registers
  logic [4:0] rows_r;
  logic [5:0] cols_r;
  logic [3:0] srow_r;
  logic [4:0] scol_r;
  logic [1:0] shead_r;
  logic [3:0] grow_r;
  logic [4:0] gcol_r;

  // Control state
  state_t          state_r, state_nxt;
  logic [1:0]      k_r, k_nxt;
  logic [WR_W-1:0] wrow_r, wrow_nxt;
  logic [WC_W-1:0] wcol_r, wcol_nxt;
  logic [1:0]      whead_r, whead_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Payload registers
  logic [2:0]      status_r, status_nxt;
  logic [NR_W-1:0] nr_r;
  logic [NC_W-1:0] nc_r;
  logic [1:0]      dir_r;
  logic            inb_r;
  logic [3:0]      out_row_r;
  logic [4:0]      out_col_r;
  logic [1:0]      out_head_r;
  logic [2:0]      out_stat_r;

  // Maze memory
  logic              maze_r [DEPTH];
  logic              mem_rd_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  // Shared neighbour unit
  logic [1:0]      dir;
  logic [NR_W-1:0] nr;
  logic [NC_W-1:0] nc;
  logic            edge_wall, inb;

  logic in_fire, cfg_we, out_load, at_goal, back_at_start;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= 5'd13;
      cols_r  <= 6'd25;
      srow_r  <= 4'd1;
      scol_r  <= 5'd0;
      shead_r <= 2'd1;
      grow_r  <= 4'd5;
      gcol_r  <= 5'd24;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_ROWS:  rows_r  <= pwdata[4:0];
        REG_COLS:  cols_r  <= pwdata[5:0];
        REG_SROW:  srow_r  <= pwdata[3:0];
        REG_SCOL:  scol_r  <= pwdata[4:0];
        REG_SHEAD: shead_r <= pwdata[1:0];
        REG_GROW:  grow_r  <= pwdata[3:0];
        REG_GCOL:  gcol_r  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[4:2])
      REG_ROWS:  prdata = {27'd0, rows_r};
      REG_COLS:  prdata = {26'd0, cols_r};
      REG_SROW:  prdata = {28'd0, srow_r};
      REG_SCOL:  prdata = {27'd0, scol_r};
      REG_SHEAD: prdata = {30'd0, shead_r};
      REG_GROW:  prdata = {28'd0, grow_r};
      REG_GCOL:  prdata = {27'd0, gcol_r};
      default:   prdata = 32'd0;
    endcase
  end

  // Neighbour in the probed direction: right of heading first, then on round
  always_comb begin
    dir       = whead_r + 2'd3 + k_r;
    nr        = {1'b0, wrow_r};
    nc        = {1'b0, wcol_r};
    edge_wall = 1'b0;
    unique case (dir)
      HEAD_S: nr = {1'b0, wrow_r} + NR_W'(1);
      HEAD_E: nc = {1'b0, wcol_r} + NC_W'(1);
      HEAD_N: begin
        edge_wall = (wrow_r == '0);
        nr        = {1'b0, wrow_r} - NR_W'(1);
      end
      default: begin
        edge_wall = (wcol_r == '0);
        nc        = {1'b0, wcol_r} - NC_W'(1);
      end
    endcase
    inb = !edge_wall
          && (32'(nr) < 32'(rows_r)) && (32'(nr) < MAX_ROWS)
          && (32'(nc) < 32'(cols_r)) && (32'(nc) < MAX_COLS);
  end

  assign mem_raddr = ADDR_W'(32'(nr) * MAX_COLS + 32'(nc));
  assign mem_re    = (state_r == ST_PROBE) && inb;
  assign mem_waddr = ADDR_W'(32'(in_cell_row) * MAX_COLS + 32'(in_cell_col));
  assign mem_we    = in_fire && (in_command == CMD_WRITE)
                     && (32'(in_cell_row) < MAX_ROWS) && (32'(in_cell_col) < MAX_COLS);

  // Maze memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      maze_r[mem_waddr] <= in_cell_open;
    end
    if (mem_re) begin
      mem_rd_r <= maze_r[mem_raddr];
    end
  end

  assign at_goal       = (wrow_r == WR_W'(grow_r)) && (wcol_r == WC_W'(gcol_r));
  assign back_at_start = (wrow_r == WR_W'(srow_r)) && (wcol_r == WC_W'(scol_r))
                         && (whead_r != shead_r);
  assign out_load      = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    wrow_nxt      = wrow_r;
    wcol_nxt      = wcol_r;
    whead_nxt     = whead_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          status_nxt = STAT_IDLE;
          if (in_command == CMD_STEP) begin
            state_nxt = ST_CHECK;
          end else begin
            state_nxt = ST_OUT;
            if (in_command == CMD_RESTART) begin
              wrow_nxt  = WR_W'(srow_r);
              wcol_nxt  = WC_W'(scol_r);
              whead_nxt = shead_r;
            end
          end
        end
      end
      ST_CHECK: begin
        k_nxt = 2'd0;
        priority if (at_goal) begin
          status_nxt = STAT_SOLVED;
          state_nxt  = ST_OUT;
        end else if (back_at_start) begin
          status_nxt = STAT_UNSOLVABLE;
          state_nxt  = ST_OUT;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (inb_r && mem_rd_r) begin
          wrow_nxt   = nr_r[WR_W-1:0];
          wcol_nxt   = nc_r[WC_W-1:0];
          whead_nxt  = dir_r;
          status_nxt = STAT_MOVED;
          state_nxt  = ST_OUT;
        end else if (k_r == 2'd3) begin
          status_nxt = STAT_NO_MOVE;
          state_nxt  = ST_OUT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_PROBE;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= 2'd0;
      wrow_r      <= WR_W'(4'd1);
      wcol_r      <= WC_W'(5'd0);
      whead_r     <= HEAD_E;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      wrow_r      <= wrow_nxt;
      wcol_r      <= wcol_nxt;
      whead_r     <= whead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: probe results and the result beat
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (state_r == ST_PROBE) begin
      nr_r  <= nr;
      nc_r  <= nc;
      dir_r <= dir;
      inb_r <= inb;
    end
    if (out_load) begin
      out_row_r  <= wrow_r[3:0];
      out_col_r  <= wcol_r[4:0];
      out_head_r <= whead_r;
      out_stat_r <= status_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_row = out_row_r;
  assign out_pos_col = out_col_r;
  assign out_heading = out_head_r;
  assign out_status  = out_stat_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while sequencer busy");

  a_last_probe_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) && (k_r == 2'd3) && !(inb_r && mem_rd_r)
    |=> (state_r == ST_OUT) && (status_r == STAT_NO_MOVE))
    else $error("fourth blocked probe did not report no move");

  a_heading_change_source: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(whead_r)
    |-> $past(state_r == ST_EVAL)
        || $past(in_valid && in_ready && (in_command == CMD_RESTART)))
    else $error("heading changed outside a move or restart");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the right-hand maze walker
// Configures the maze area, start and goal over the register port, then sends
// cell writes, restarts and walk steps through the input channel. An
// independent wall-follower predicts position, heading and status for each
// accepted beat, and every result beat is checked against it. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import rhmw_pkg::*;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1400;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] row;
    logic [4:0] col;
    logic       cell_open;
  } beat_t;

  typedef struct packed {
    logic [3:0] row;
    logic [4:0] col;
    logic [1:0] hd;
    logic [2:0] st;
  } pos_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_NONE;
  logic [3:0]  in_cell_row = '0;
  logic [4:0]  in_cell_col = '0;
  logic        in_cell_open = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_pos_row;
  logic [4:0]  out_pos_col;
  logic [1:0]  out_heading;
  logic [2:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Register copy, walker copy and maze copy kept by the predictor
  logic [4:0] cfg_rows = 5'd13;
  logic [5:0] cfg_cols = 6'd25;
  logic [3:0] cfg_srow = 4'd1;
  logic [4:0] cfg_scol = 5'd0;
  logic [1:0] cfg_shead = HEAD_E;
  logic [3:0] cfg_grow = 4'd5;
  logic [4:0] cfg_gcol = 5'd24;
  int         used_rows = 13;
  int         used_cols = 25;
  logic [3:0] walk_row = 4'd1;
  logic [4:0] walk_col = 5'd0;
  logic [1:0] walk_hd = HEAD_E;
  logic       maze_map [MAX_ROWS][MAX_COLS];
  logic [2:0] last_status = STAT_IDLE;

  beat_t cmd_queue[$];
  pos_t  expected_pos[$];
  int    beats_queued = 0;
  int    beats_done = 0;
  int    useful_beats = 0;
  int    bad_count = 0;
  int    cycle_count = 0;
  int    send_gap_max = 14;
  int    take_gap_max = 14;
  int    send_wait = 0;
  int    take_wait = 0;
  logic  in_took = 1'b0;
  logic  out_took = 1'b0;

  right_hand_maze_walker dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .in_cell_open (in_cell_open),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pos_row  (out_pos_row),
    .out_pos_col  (out_pos_col),
    .out_heading  (out_heading),
    .out_status   (out_status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // True when the neighbour in direction dir is inside the used area and open
  function automatic logic cell_open_toward(input logic [1:0] dir);
    int r;
    int c;
    r = int'(walk_row);
    c = int'(walk_col);
    case (dir)
      HEAD_S: r = r + 1;
      HEAD_E: c = c + 1;
      HEAD_N: r = r - 1;
      default: c = c - 1;
    endcase
    if (r < 0 || c < 0 || r >= used_rows || c >= used_cols) return 1'b0;
    return maze_map[r][c];
  endfunction

  // One wall-follower step: goal, then loop back to start, then right-hand try order
  function automatic logic [2:0] walk_step();
    logic [2:0] st;
    logic [1:0] dir;
    if (walk_row == cfg_grow && walk_col == cfg_gcol) return STAT_SOLVED;
    if (walk_row == cfg_srow && walk_col == cfg_scol && walk_hd != cfg_shead)
      return STAT_UNSOLVABLE;
    st = STAT_NO_MOVE;
    dir = walk_hd + 2'd3;
    for (int k = 0; k < 4; k++) begin
      if (st == STAT_NO_MOVE && cell_open_toward(dir)) begin
        case (dir)
          HEAD_S: walk_row = walk_row + 4'd1;
          HEAD_E: walk_col = walk_col + 5'd1;
          HEAD_N: walk_row = walk_row - 4'd1;
          default: walk_col = walk_col - 5'd1;
        endcase
        walk_hd = dir;
        st = STAT_MOVED;
      end
      dir = dir + 2'd1;
    end
    return st;
  endfunction

  // Apply one accepted beat and queue the result it must produce
  task automatic walker_apply(input beat_t b);
    logic [2:0] st;
    st = STAT_IDLE;
    case (b.cmd)
      CMD_WRITE: maze_map[b.row][b.col] = b.cell_open;
      CMD_STEP: st = walk_step();
      CMD_RESTART: begin
        walk_row = cfg_srow;
        walk_col = cfg_scol;
        walk_hd = cfg_shead;
      end
      default: ;
    endcase
    expected_pos.push_back('{walk_row, walk_col, walk_hd, st});
    last_status = st;
  endtask

  // Input driver: hold until accepted, then idle for a drawn number of cycles
  always @(negedge clk) begin
    beat_t nxt;
    if (rst_n) begin
      if (in_took) send_wait = $urandom_range(0, send_gap_max);
      if (in_valid && !in_took) begin
        // hold the beat
      end else if (send_wait != 0) begin
        send_wait = send_wait - 1;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        nxt = cmd_queue.pop_front();
        in_valid <= 1'b1;
        in_command <= nxt.cmd;
        in_cell_row <= nxt.row;
        in_cell_col <= nxt.col;
        in_cell_open <= nxt.cell_open;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure: stall for a drawn number of cycles after each beat
  always @(negedge clk) begin
    if (out_took) take_wait = $urandom_range(0, take_gap_max);
    if (take_wait != 0) begin
      take_wait = take_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check results, predict accepted beats, watch the cycle budget
  always @(posedge clk) begin
    pos_t got;
    pos_t want;
    cycle_count = cycle_count + 1;
    in_took <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pos_row, out_pos_col, out_heading, out_status};
      if (expected_pos.size() == 0) begin
        bad_count = bad_count + 1;
        if (bad_count <= 10)
          $display("unexpected result: row %0d col %0d heading %0d status %0d",
                   got.row, got.col, got.hd, got.st);
      end else begin
        want = expected_pos.pop_front();
        if (got !== want) begin
          bad_count = bad_count + 1;
          if (bad_count <= 10)
            $display({"result %0d: expected row %0d col %0d heading %0d status %0d,",
                      " got %0d %0d %0d %0d"},
                     beats_done, want.row, want.col, want.hd, want.st,
                     got.row, got.col, got.hd, got.st);
        end
      end
      beats_done = beats_done + 1;
    end
    if (rst_n && in_valid && in_ready)
      walker_apply('{in_command, in_cell_row, in_cell_col, in_cell_open});
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic queue_beat(input logic [1:0] cmd, input logic [3:0] row,
                            input logic [4:0] col, input logic cell_open);
    cmd_queue.push_back('{cmd, row, col, cell_open});
    beats_queued = beats_queued + 1;
    if (cmd != CMD_NONE) useful_beats = useful_beats + 1;
  endtask

  // Beat with random content in the fields the command may ignore
  task automatic queue_junk(input logic [1:0] cmd);
    logic [31:0] rnd;
    rnd = $urandom;
    queue_beat(cmd, rnd[3:0], rnd[8:4], rnd[9]);
  endtask

  task automatic wait_idle();
    while (beats_done < beats_queued) @(negedge clk);
  endtask

  // Register write: setup beat, then access beat until pready
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROWS: begin
        cfg_rows = val[4:0];
        used_rows = (int'(cfg_rows) > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
      end
      REG_COLS: begin
        cfg_cols = val[5:0];
        used_cols = (int'(cfg_cols) > MAX_COLS) ? MAX_COLS : int'(cfg_cols);
      end
      REG_SROW: cfg_srow = val[3:0];
      REG_SCOL: cfg_scol = val[4:0];
      REG_SHEAD: cfg_shead = val[1:0];
      REG_GROW: cfg_grow = val[3:0];
      default: cfg_gcol = val[4:0];
    endcase
  endtask

  // Drain the block, then rewrite every register
  task automatic set_layout(input logic [4:0] rows, input logic [5:0] cols,
                            input logic [3:0] srow, input logic [4:0] scol,
                            input logic [1:0] shead, input logic [3:0] grow,
                            input logic [4:0] gcol);
    wait_idle();
    cfg_write(REG_ROWS, 32'(rows));
    cfg_write(REG_COLS, 32'(cols));
    cfg_write(REG_SROW, 32'(srow));
    cfg_write(REG_SCOL, 32'(scol));
    cfg_write(REG_SHEAD, 32'(shead));
    cfg_write(REG_GROW, 32'(grow));
    cfg_write(REG_GCOL, 32'(gcol));
  endtask

  // Build a fresh maze over the used area, then walk it in batches until it ends or hits step_cap
  task automatic run_walk(input bit do_restart, input int step_cap);
    int r;
    int c;
    int n;
    int taken;
    bit ended;
    for (r = 0; r < used_rows; r++) begin
      for (c = 0; c < used_cols; c++) begin
        queue_beat(CMD_WRITE, r[3:0], c[4:0], $urandom_range(0, 2) != 0);
        if ($urandom_range(0, 15) == 0) queue_junk($urandom_range(0, 1) ? CMD_NONE : CMD_WRITE);
      end
    end
    if (do_restart) queue_junk(CMD_RESTART);
    taken = 0;
    ended = 1'b0;
    while (!ended && taken < step_cap) begin
      repeat (6) begin
        n = $urandom_range(0, 31);
        if (n == 0) begin
          queue_junk(CMD_NONE);
        end else if (n == 1) begin
          queue_junk(CMD_RESTART);
        end else if (n == 2 && used_rows != 0 && used_cols != 0) begin
          r = $urandom_range(0, used_rows - 1);
          c = $urandom_range(0, used_cols - 1);
          queue_beat(CMD_WRITE, r[3:0], c[4:0], 1'($urandom_range(0, 1)));
        end else begin
          queue_junk(CMD_STEP);
        end
      end
      taken = taken + 6;
      wait_idle();
      ended = (last_status == STAT_SOLVED || last_status == STAT_UNSOLVABLE ||
               last_status == STAT_NO_MOVE);
    end
    // a finished walk must keep giving the same answer
    queue_junk(CMD_STEP);
  endtask

  initial begin
    logic [4:0] lay_rows;
    logic [5:0] lay_cols;
    logic [3:0] lay_srow;
    logic [4:0] lay_scol;
    logic [1:0] lay_shead;
    logic [3:0] lay_grow;
    logic [4:0] lay_gcol;
    int er;
    int ec;
    int phase;
    int walks;
    int cap;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset walker seen through an unknown command; store corner writes
    queue_beat(CMD_NONE, 4'd9, 5'd17, 1'b1);
    queue_beat(CMD_WRITE, 4'd15, 5'd31, 1'b1);
    queue_beat(CMD_WRITE, 4'd15, 5'd31, 1'b0);
    queue_beat(CMD_RESTART, 4'd15, 5'd31, 1'b1);

    // Two-by-three maze: three moves along the wall, then solved twice
    set_layout(5'd2, 6'd3, 4'd0, 5'd0, HEAD_E, 4'd1, 5'd2);
    queue_beat(CMD_WRITE, 4'd0, 5'd0, 1'b1);
    queue_beat(CMD_WRITE, 4'd0, 5'd1, 1'b1);
    queue_beat(CMD_WRITE, 4'd0, 5'd2, 1'b0);
    queue_beat(CMD_WRITE, 4'd1, 5'd0, 1'b0);
    queue_beat(CMD_WRITE, 4'd1, 5'd1, 1'b1);
    queue_beat(CMD_WRITE, 4'd1, 5'd2, 1'b1);
    queue_beat(CMD_RESTART, 4'd0, 5'd0, 1'b0);
    repeat (5) queue_beat(CMD_STEP, 4'd0, 5'd0, 1'b0);

    // Dead-end corridor with the goal out of reach: back at start facing west
    set_layout(5'd1, 6'd2, 4'd0, 5'd0, HEAD_E, 4'd15, 5'd31);
    queue_beat(CMD_WRITE, 4'd0, 5'd1, 1'b1);
    queue_beat(CMD_RESTART, 4'd0, 5'd0, 1'b0);
    repeat (3) queue_beat(CMD_STEP, 4'd0, 5'd0, 1'b0);

    // Zero columns: every neighbour is a wall
    set_layout(5'd1, 6'd0, 4'd0, 5'd0, HEAD_E, 4'd15, 5'd31);
    queue_beat(CMD_RESTART, 4'd0, 5'd0, 1'b0);
    queue_beat(CMD_STEP, 4'd0, 5'd0, 1'b0);

    // Random layouts and mazes
    phase = 0;
    while (useful_beats < ITEM_TARGET) begin
      walks = $urandom_range(1, 3);
      if (phase == 1) begin
        // oversized counts at their field maxima, start and goal in far corners
        lay_rows = 5'd31;
        lay_cols = 6'd63;
        lay_srow = 4'd15;
        lay_scol = 5'd31;
        lay_grow = 4'd0;
        lay_gcol = 5'd0;
        walks = 1;
      end else if (phase == 3) begin
        lay_rows = 5'd16;
        lay_cols = 6'd32;
        lay_srow = 4'd0;
        lay_scol = 5'd0;
        lay_grow = 4'd15;
        lay_gcol = 5'd31;
        walks = 1;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            lay_rows = 5'd0;
            lay_cols = 6'($urandom_range(1, 8));
          end
          1: begin
            lay_rows = 5'($urandom_range(1, 6));
            lay_cols = 6'd0;
          end
          2: begin
            lay_rows = 5'($urandom_range(1, 16));
            lay_cols = 6'($urandom_range(1, 3));
          end
          3: begin
            lay_rows = 5'($urandom_range(1, 2));
            lay_cols = 6'($urandom_range(1, 32));
          end
          default: begin
            lay_rows = 5'($urandom_range(1, 6));
            lay_cols = 6'($urandom_range(1, 8));
          end
        endcase
        er = int'(lay_rows);
        ec = int'(lay_cols);
        // start mostly inside the used area, now and then anywhere
        if (er == 0 || ec == 0 || $urandom_range(0, 4) == 0) begin
          lay_srow = 4'($urandom_range(0, 15));
          lay_scol = 5'($urandom_range(0, 31));
        end else begin
          lay_srow = 4'($urandom_range(0, er - 1));
          lay_scol = 5'($urandom_range(0, ec - 1));
        end
        if ($urandom_range(0, 7) == 0) begin
          lay_grow = lay_srow;
          lay_gcol = lay_scol;
        end else if (er == 0 || ec == 0 || $urandom_range(0, 4) == 0) begin
          lay_grow = 4'($urandom_range(0, 15));
          lay_gcol = 5'($urandom_range(0, 31));
        end else begin
          lay_grow = 4'($urandom_range(0, er - 1));
          lay_gcol = 5'($urandom_range(0, ec - 1));
        end
      end
      lay_shead = 2'($urandom_range(0, 3));
      set_layout(lay_rows, lay_cols, lay_srow, lay_scol, lay_shead, lay_grow, lay_gcol);
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      cap = (used_rows * used_cols > 100) ? 120 : 4 * used_rows * used_cols + 12;
      for (int w = 0; w < walks; w++)
        run_walk(!(w == 0 && $urandom_range(0, 5) == 0), cap);
      phase = phase + 1;
    end

    // Drain, then idle on so that stray results still reach the monitor
    wait_idle();
    repeat (32) @(negedge clk);
    if (expected_pos.size() != 0) bad_count = bad_count + 1;
    if (bad_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
